@@ rtl/vrp_pkg.sv @@
// ----------------------------------------------------------------------------
// Video register port package
// Shared types, codes and address mapping functions for the register port.
// ----------------------------------------------------------------------------
package vrp_pkg;

  localparam int unsigned PatternBytes   = 8192;
  localparam int unsigned NametableBytes = 4096;
  localparam int unsigned PaletteBytes   = 32;

  localparam int unsigned PatAddrW = $clog2(PatternBytes);
  localparam int unsigned NtAddrW  = $clog2(NametableBytes);
  localparam int unsigned PalAddrW = $clog2(PaletteBytes);

  // Beat modes.
  localparam logic [1:0] MODE_READ   = 2'd0;
  localparam logic [1:0] MODE_WRITE  = 2'd1;
  localparam logic [1:0] MODE_STATUS = 2'd2;

  // Register indexes.
  localparam logic [2:0] REG_CONTROL  = 3'd0;
  localparam logic [2:0] REG_MASK     = 3'd1;
  localparam logic [2:0] REG_STATUS   = 3'd2;
  localparam logic [2:0] REG_OAM_ADDR = 3'd3;
  localparam logic [2:0] REG_OAM_DATA = 3'd4;
  localparam logic [2:0] REG_SCROLL   = 3'd5;
  localparam logic [2:0] REG_ADDR     = 3'd6;
  localparam logic [2:0] REG_DATA     = 3'd7;

  // Nametable mirroring modes.
  localparam logic [1:0] MIRROR_SINGLE     = 2'd0;
  localparam logic [1:0] MIRROR_FOUR       = 2'd1;
  localparam logic [1:0] MIRROR_HORIZONTAL = 2'd2;
  localparam logic [1:0] MIRROR_VERTICAL   = 2'd3;

  // Video bus regions.
  localparam logic [1:0] REGION_NONE    = 2'd0;
  localparam logic [1:0] REGION_PATTERN = 2'd1;
  localparam logic [1:0] REGION_NAMETBL = 2'd2;
  localparam logic [1:0] REGION_PALETTE = 2'd3;

  typedef struct packed {
    logic        rd;
    logic        wr;
    logic [15:0] addr;
    logic [7:0]  wdata;
  } vram_req_t;

  function automatic logic [NtAddrW-1:0] nt_index(input logic [15:0] a,
                                                  input logic [1:0]  mirror);
    logic [11:0] q;
    q = a[11:0];
    case (mirror)
      MIRROR_SINGLE: q[11:10] = 2'b00;
      MIRROR_FOUR:   q = a[11:0];
      MIRROR_HORIZONTAL: begin
        if (q[11:10] == 2'b01) begin
          q[11:10] = 2'b00;
        end else if (q[11:10] == 2'b10) begin
          q[11:10] = 2'b11;
        end
      end
      default: begin
        if (q[11:10] == 2'b01) begin
          q[11:10] = 2'b11;
        end else if (q[11:10] == 2'b10) begin
          q[11:10] = 2'b00;
        end
      end
    endcase
    return q[NtAddrW-1:0];
  endfunction

  function automatic logic [PalAddrW-1:0] pal_index(input logic [15:0] a);
    logic [4:0] p;
    p = a[4:0];
    if (p[4] && (p[1:0] == 2'b00)) begin
      p = p & 5'h0C;
    end
    return p[PalAddrW-1:0];
  endfunction

  function automatic logic [1:0] region_of(input logic [15:0] a);
    logic [1:0] r;
    if (a[15:14] != 2'b00) begin
      r = REGION_NONE;
    end else if (!a[13]) begin
      r = REGION_PATTERN;
    end else if (a[13:8] == 6'h3F) begin
      r = REGION_PALETTE;
    end else begin
      r = REGION_NAMETBL;
    end
    return r;
  endfunction

endpackage

@@ rtl/vrp_if.sv @@
// ----------------------------------------------------------------------------
// Video register port channels
// Valid/ready channels for register beats, result beats and configuration.
// ----------------------------------------------------------------------------
interface vrp_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [2:0] reg_index;
  logic [7:0] write_data;

  modport source (output valid, output mode, output reg_index, output write_data,
                  input ready);
  modport sink (input valid, input mode, input reg_index, input write_data,
                output ready);
endinterface

interface vrp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;

  modport source (output valid, output read_data, input ready);
  modport sink (input valid, input read_data, output ready);
endinterface

interface vrp_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] mirror_mode;

  modport source (output valid, output mirror_mode, input ready);
  modport sink (input valid, input mirror_mode, output ready);
endinterface

@@ rtl/vrp_vram.sv @@
// ----------------------------------------------------------------------------
// Video bus memories
// Pattern, nametable and palette memories with registered read data.
// ----------------------------------------------------------------------------
module vrp_vram (
  input  logic                clk,
  input  vrp_pkg::vram_req_t  req,
  input  logic [1:0]          mirror_mode,
  output logic [7:0]          rdata
);

  logic [7:0] pat_mem [vrp_pkg::PatternBytes];
  logic [7:0] nt_mem  [vrp_pkg::NametableBytes];
  logic [7:0] pal_mem [vrp_pkg::PaletteBytes];

  logic [1:0]                    region;
  logic [vrp_pkg::PatAddrW-1:0]  pat_idx;
  logic [vrp_pkg::NtAddrW-1:0]   nt_idx;
  logic [vrp_pkg::PalAddrW-1:0]  pal_idx;

  logic [7:0] pat_q_r;
  logic [7:0] nt_q_r;
  logic [7:0] pal_q_r;
  logic [1:0] region_r;

  assign region  = vrp_pkg::region_of(req.addr);
  assign pat_idx = req.addr[vrp_pkg::PatAddrW-1:0];
  assign nt_idx  = vrp_pkg::nt_index(req.addr, mirror_mode);
  assign pal_idx = vrp_pkg::pal_index(req.addr);

  always_ff @(posedge clk) begin
    if (req.wr && (region == vrp_pkg::REGION_PATTERN)) begin
      pat_mem[pat_idx] <= req.wdata;
    end
    if (req.rd) begin
      pat_q_r <= pat_mem[pat_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (req.wr && (region == vrp_pkg::REGION_NAMETBL)) begin
      nt_mem[nt_idx] <= req.wdata;
    end
    if (req.rd) begin
      nt_q_r <= nt_mem[nt_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (req.wr && (region == vrp_pkg::REGION_PALETTE)) begin
      pal_mem[pal_idx] <= req.wdata;
    end
    if (req.rd) begin
      pal_q_r <= pal_mem[pal_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd) begin
      region_r <= region;
    end
  end

  always_comb begin
    unique case (region_r)
      vrp_pkg::REGION_PATTERN: rdata = pat_q_r;
      vrp_pkg::REGION_NAMETBL: rdata = nt_q_r;
      vrp_pkg::REGION_PALETTE: rdata = pal_q_r;
      default:                 rdata = 8'h00;
    endcase
  end

endmodule

@@ rtl/video_register_port_with_vram_mapping.sv @@
// A result beat passes the s2 stage and the output register after its register beat
// is accepted. Throughput: one register beat per cycle unless out_bus stalls; the
// video memory read is registered once and the read buffer is updated in the following
// stage, in beat order. Reset (rst_n, synchronous, active low) clears the state
// registers, sets vertical mirroring, empties the pipeline; video memories are not cleared.
// ----------------------------------------------------------------------------
// Video register port with video memory mapping
// CPU-side register file of a tile video processor and its video bus.
// ----------------------------------------------------------------------------
module video_register_port_with_vram_mapping (
  input  logic  clk,
  input  logic  rst_n,
  vrp_in_if.sink    in_bus,
  vrp_out_if.source out_bus,
  vrp_cfg_if.sink   cfg_bus
);

  logic [1:0]  mirror_mode_r;
  logic [7:0]  control_r, control_nxt;
  logic [7:0]  status_r, status_nxt;
  logic [7:0]  oam_data_r, oam_data_nxt;
  logic        toggle_r, toggle_nxt;
  logic [15:0] temp_addr_r, temp_addr_nxt;
  logic [15:0] vram_addr_r, vram_addr_nxt;
  logic [7:0]  read_buf_r, read_buf_nxt;

  logic        s2_valid_r;
  logic        s2_data_rd_r, s2_data_rd_nxt;
  logic        s2_pal_r;
  logic [7:0]  s2_res_r, s2_res_nxt;

  logic        out_valid_r;
  logic [7:0]  out_data_r, out_data_nxt;

  logic        accept;
  logic        s2_adv;
  logic [15:0] step;
  logic [7:0]  mem_rdata;
  vrp_pkg::vram_req_t req;

  assign s2_adv        = !out_valid_r || out_bus.ready;
  assign in_bus.ready  = !s2_valid_r || s2_adv;
  assign accept        = in_bus.valid && in_bus.ready;
  assign cfg_bus.ready = 1'b1;
  assign out_bus.valid     = out_valid_r;
  assign out_bus.read_data = out_data_r;
  assign step = control_r[2] ? 16'd32 : 16'd1;

  always_comb begin
    control_nxt    = control_r;
    status_nxt     = status_r;
    oam_data_nxt   = oam_data_r;
    toggle_nxt     = toggle_r;
    temp_addr_nxt  = temp_addr_r;
    vram_addr_nxt  = vram_addr_r;
    s2_res_nxt     = 8'h00;
    s2_data_rd_nxt = 1'b0;
    req.rd         = 1'b0;
    req.wr         = 1'b0;
    req.addr       = vram_addr_r;
    req.wdata      = in_bus.write_data;
    if (accept) begin
      case (in_bus.mode)
        vrp_pkg::MODE_READ: begin
          unique case (in_bus.reg_index)
            vrp_pkg::REG_STATUS: begin
              s2_res_nxt    = status_r;
              toggle_nxt    = 1'b0;
              status_nxt[7] = 1'b0;
            end
            vrp_pkg::REG_OAM_DATA: s2_res_nxt = oam_data_r;
            vrp_pkg::REG_DATA: begin
              req.rd         = 1'b1;
              s2_data_rd_nxt = 1'b1;
              vram_addr_nxt  = vram_addr_r + step;
            end
            default: s2_res_nxt = 8'h00;
          endcase
        end
        vrp_pkg::MODE_WRITE: begin
          unique case (in_bus.reg_index)
            vrp_pkg::REG_CONTROL: begin
              control_nxt   = in_bus.write_data;
              temp_addr_nxt = {temp_addr_r[15:12], in_bus.write_data[1:0],
                               temp_addr_r[9:0]};
            end
            vrp_pkg::REG_OAM_DATA: oam_data_nxt = in_bus.write_data;
            vrp_pkg::REG_SCROLL: begin
              toggle_nxt = !toggle_r;
              if (!toggle_r) begin
                temp_addr_nxt = {temp_addr_r[15:5], in_bus.write_data[7:3]};
              end else begin
                temp_addr_nxt = {temp_addr_r[15], in_bus.write_data[2:0],
                                 temp_addr_r[11:10], in_bus.write_data[7:3],
                                 temp_addr_r[4:0]};
              end
            end
            vrp_pkg::REG_ADDR: begin
              toggle_nxt = !toggle_r;
              if (!toggle_r) begin
                temp_addr_nxt = {2'b00, in_bus.write_data[5:0], temp_addr_r[7:0]};
              end else begin
                temp_addr_nxt = {temp_addr_r[15:8], in_bus.write_data};
                vram_addr_nxt = {temp_addr_r[15:8], in_bus.write_data};
              end
            end
            vrp_pkg::REG_DATA: begin
              req.wr        = 1'b1;
              vram_addr_nxt = vram_addr_r + step;
            end
            default: s2_res_nxt = 8'h00;
          endcase
        end
        vrp_pkg::MODE_STATUS: status_nxt = {in_bus.write_data[7:5], status_r[4:0]};
        default: s2_res_nxt = 8'h00;
      endcase
    end
  end

  always_comb begin
    read_buf_nxt = read_buf_r;
    out_data_nxt = s2_res_r;
    if (s2_data_rd_r) begin
      read_buf_nxt = mem_rdata;
      out_data_nxt = s2_pal_r ? mem_rdata : read_buf_r;
    end
  end

  vrp_vram u_vram (
    .clk         (clk),
    .req         (req),
    .mirror_mode (mirror_mode_r),
    .rdata       (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mirror_mode_r <= vrp_pkg::MIRROR_VERTICAL;
    end else if (cfg_bus.valid) begin
      mirror_mode_r <= cfg_bus.mirror_mode;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      control_r   <= 8'h00;
      status_r    <= 8'h00;
      oam_data_r  <= 8'h00;
      toggle_r    <= 1'b0;
      temp_addr_r <= 16'h0000;
      vram_addr_r <= 16'h0000;
      read_buf_r  <= 8'h00;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      control_r   <= control_nxt;
      status_r    <= status_nxt;
      oam_data_r  <= oam_data_nxt;
      toggle_r    <= toggle_nxt;
      temp_addr_r <= temp_addr_nxt;
      vram_addr_r <= vram_addr_nxt;
      if (s2_adv) begin
        out_valid_r <= s2_valid_r;
        if (s2_valid_r) begin
          read_buf_r <= read_buf_nxt;
        end
      end
      if (in_bus.ready) begin
        s2_valid_r <= accept;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s2_adv && s2_valid_r) begin
      out_data_r <= out_data_nxt;
    end
    if (accept) begin
      s2_res_r     <= s2_res_nxt;
      s2_data_rd_r <= s2_data_rd_nxt;
      s2_pal_r     <= (vram_addr_r[15:8] == 8'h3F);
    end
  end

endmodule

@@ test/video_register_port_with_vram_mapping_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Video register port testbench
// Sends register beats in bursts with random gaps while the result side
// stalls on a pattern of its own. A behavioral model of the registers, the
// read buffer and the video memories predicts every read_data beat, and each
// result is checked against the oldest prediction.
// ----------------------------------------------------------------------------
module video_register_port_with_vram_mapping_tb;

  localparam logic [1:0] ModeUnused = 2'd3;

  localparam logic [1:0] StallNone   = 2'd0;
  localparam logic [1:0] StallRandom = 2'd1;
  localparam logic [1:0] StallSparse = 2'd2;
  localparam logic [1:0] StallLong   = 2'd3;

  localparam int unsigned QuietLimit  = 2000;
  localparam int unsigned RandomBeats = 1200;

  localparam logic [1:0] MirrorOrder [4] = '{vrp_pkg::MIRROR_SINGLE, vrp_pkg::MIRROR_FOUR,
                                             vrp_pkg::MIRROR_HORIZONTAL,
                                             vrp_pkg::MIRROR_VERTICAL};
  localparam logic [15:0] CornerBases [6] = '{16'h0000, 16'h1FFF, 16'h1FF8,
                                              16'h3EF8, 16'h3FF8, 16'h3FE0};

  logic clk;
  logic rst_n;

  vrp_in_if  in_if ();
  vrp_out_if out_if ();
  vrp_cfg_if cfg_if ();

  video_register_port_with_vram_mapping u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_if),
    .out_bus (out_if),
    .cfg_bus (cfg_if)
  );

  logic [1:0]  mirror_q;
  logic [7:0]  ctrl_q;
  logic [7:0]  mask_q;
  logic [7:0]  status_q;
  logic [7:0]  oam_addr_q;
  logic [7:0]  oam_data_q;
  logic        toggle_q;
  logic [2:0]  fine_x_q;
  logic [15:0] t_addr;
  logic [15:0] v_addr;
  logic [7:0]  rd_buf;

  logic [7:0] pat_mem [vrp_pkg::PatternBytes];
  logic [7:0] nt_mem  [vrp_pkg::NametableBytes];
  logic [7:0] pal_mem [vrp_pkg::PaletteBytes];
  bit         pat_set [vrp_pkg::PatternBytes];
  bit         nt_set  [vrp_pkg::NametableBytes];
  bit         pal_set [vrp_pkg::PaletteBytes];

  logic [7:0]  read_data_q [$];
  logic [7:0]  want;
  int unsigned error_count;
  int unsigned beats_sent;
  int unsigned burst_left;
  int unsigned quiet_cycles;
  int unsigned stall_left;
  logic [1:0]  stall_style;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic [vrp_pkg::NtAddrW-1:0] nt_slot(input logic [15:0] a);
    logic [1:0] quad;
    quad = a[11:10];
    case (mirror_q)
      vrp_pkg::MIRROR_SINGLE:     quad = 2'b00;
      vrp_pkg::MIRROR_HORIZONTAL: quad = {2{quad[1]}};
      vrp_pkg::MIRROR_VERTICAL:   quad = {2{quad[0]}};
      default:                    quad = a[11:10];
    endcase
    return {quad, a[9:0]};
  endfunction

  function automatic logic [vrp_pkg::PalAddrW-1:0] pal_slot(input logic [15:0] a);
    logic [4:0] p;
    p = a[4:0];
    if (p[1:0] == 2'b00) begin
      p[4] = 1'b0;
    end
    return p;
  endfunction

  function automatic bit vram_safe(input logic [15:0] a);
    if (a < 16'h2000) begin
      return pat_set[a[12:0]];
    end else if (a < 16'h3F00) begin
      return nt_set[nt_slot(a)];
    end else if (a < 16'h4000) begin
      return pal_set[pal_slot(a)];
    end
    return 1'b1;
  endfunction

  function automatic logic [7:0] vram_peek(input logic [15:0] a);
    if (a < 16'h2000) begin
      return pat_mem[a[12:0]];
    end else if (a < 16'h3F00) begin
      return nt_mem[nt_slot(a)];
    end else if (a < 16'h4000) begin
      return pal_mem[pal_slot(a)];
    end
    return 8'h00;
  endfunction

  function automatic void vram_poke(input logic [15:0] a, input logic [7:0] d);
    if (a < 16'h2000) begin
      pat_mem[a[12:0]] = d;
      pat_set[a[12:0]] = 1'b1;
    end else if (a < 16'h3F00) begin
      nt_mem[nt_slot(a)] = d;
      nt_set[nt_slot(a)] = 1'b1;
    end else if (a < 16'h4000) begin
      pal_mem[pal_slot(a)] = d;
      pal_set[pal_slot(a)] = 1'b1;
    end
  endfunction

  function automatic void step_vram();
    v_addr = v_addr + (ctrl_q[2] ? 16'd32 : 16'd1);
  endfunction

  function automatic logic [7:0] port_result(input logic [1:0] mode, input logic [2:0] idx,
                                             input logic [7:0] data);
    logic [7:0] d;
    d = 8'h00;
    case (mode)
      vrp_pkg::MODE_READ: begin
        case (idx)
          vrp_pkg::REG_STATUS: begin
            d = status_q;
            toggle_q = 1'b0;
            status_q[7] = 1'b0;
          end
          vrp_pkg::REG_OAM_DATA: d = oam_data_q;
          vrp_pkg::REG_DATA: begin
            d = rd_buf;
            rd_buf = vram_peek(v_addr);
            if (v_addr >= 16'h3F00 && v_addr < 16'h4000) begin
              d = rd_buf;
            end
            step_vram();
          end
          default: ;
        endcase
      end
      vrp_pkg::MODE_WRITE: begin
        case (idx)
          vrp_pkg::REG_CONTROL: begin
            ctrl_q = data;
            t_addr[11:10] = data[1:0];
          end
          vrp_pkg::REG_MASK:     mask_q = data;
          vrp_pkg::REG_OAM_ADDR: oam_addr_q = data;
          vrp_pkg::REG_OAM_DATA: oam_data_q = data;
          vrp_pkg::REG_SCROLL: begin
            if (!toggle_q) begin
              fine_x_q = data[2:0];
              t_addr[4:0] = data[7:3];
            end else begin
              t_addr[9:5] = data[7:3];
              t_addr[14:12] = data[2:0];
            end
            toggle_q = !toggle_q;
          end
          vrp_pkg::REG_ADDR: begin
            if (!toggle_q) begin
              t_addr[15:14] = 2'b00;
              t_addr[13:8] = data[5:0];
            end else begin
              t_addr[7:0] = data;
              v_addr = t_addr;
            end
            toggle_q = !toggle_q;
          end
          vrp_pkg::REG_DATA: begin
            vram_poke(v_addr, data);
            step_vram();
          end
          default: ;
        endcase
      end
      vrp_pkg::MODE_STATUS: status_q[7:5] = data[7:5];
      default: ;
    endcase
    return d;
  endfunction

  task automatic send_beat(input logic [1:0] mode, input logic [2:0] idx,
                           input logic [7:0] data);
    logic [1:0] m;
    m = mode;
    // A data read of a never-written entry becomes a write to that entry.
    if (m == vrp_pkg::MODE_READ && idx == vrp_pkg::REG_DATA && !vram_safe(v_addr)) begin
      m = vrp_pkg::MODE_WRITE;
    end
    @(negedge clk);
    if (burst_left == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? 150 : $urandom_range(1, 24);
    end
    in_if.valid      <= 1'b1;
    in_if.mode       <= m;
    in_if.reg_index  <= idx;
    in_if.write_data <= data;
    do @(posedge clk); while (!in_if.ready);
    burst_left--;
    beats_sent++;
    read_data_q.push_back(port_result(m, idx, data));
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_if.valid <= 1'b0;
    burst_left = 0;
    while (read_data_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_mirroring(input logic [1:0] m);
    drain_results();
    @(negedge clk);
    cfg_if.valid       <= 1'b1;
    cfg_if.mirror_mode <= m;
    do @(posedge clk); while (!cfg_if.ready);
    mirror_q = m;
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic point_vram(input logic [15:0] a);
    logic [1:0] junk;
    junk = 2'($urandom_range(0, 3));
    if (toggle_q) begin
      send_beat(vrp_pkg::MODE_READ, vrp_pkg::REG_STATUS, 8'h00);
    end
    send_beat(vrp_pkg::MODE_WRITE, vrp_pkg::REG_ADDR, {junk, a[13:8]});
    send_beat(vrp_pkg::MODE_WRITE, vrp_pkg::REG_ADDR, a[7:0]);
  endtask

  task automatic test_register_file();
    send_beat(vrp_pkg::MODE_READ, vrp_pkg::REG_CONTROL, 8'hFF);
    send_beat(vrp_pkg::MODE_READ, vrp_pkg::REG_MASK, 8'h00);
    send_beat(vrp_pkg::MODE_READ, vrp_pkg::REG_STATUS, 8'hFF);
    send_beat(vrp_pkg::MODE_READ, vrp_pkg::REG_OAM_ADDR, 8'h00);
    send_beat(vrp_pkg::MODE_READ, vrp_pkg::REG_OAM_DATA, 8'hFF);
    send_beat(vrp_pkg::MODE_READ, vrp_pkg::REG_SCROLL, 8'h00);
    send_beat(vrp_pkg::MODE_READ, vrp_pkg::REG_ADDR, 8'hFF);
    send_beat(vrp_pkg::MODE_WRITE, vrp_pkg::REG_CONTROL, 8'hFB);
    send_beat(vrp_pkg::MODE_WRITE, vrp_pkg::REG_MASK, 8'hFF);
    send_beat(vrp_pkg::MODE_WRITE, vrp_pkg::REG_OAM_ADDR, 8'hFF);
    send_beat(vrp_pkg::MODE_WRITE, vrp_pkg::REG_OAM_DATA, 8'hA5);
    send_beat(vrp_pkg::MODE_READ, vrp_pkg::REG_OAM_DATA, 8'h00);
    send_beat(vrp_pkg::MODE_WRITE, vrp_pkg::REG_STATUS, 8'hFF);
    send_beat(ModeUnused, vrp_pkg::REG_DATA, 8'hFF);
    send_beat(ModeUnused, vrp_pkg::REG_STATUS, 8'h00);
  endtask

  task automatic test_status_flags();
    send_beat(vrp_pkg::MODE_STATUS, vrp_pkg::REG_CONTROL, 8'hFF);
    send_beat(vrp_pkg::MODE_READ, vrp_pkg::REG_STATUS, 8'h00);
    send_beat(vrp_pkg::MODE_READ, vrp_pkg::REG_STATUS, 8'h00);
    send_beat(vrp_pkg::MODE_WRITE, vrp_pkg::REG_SCROLL, 8'hFF);
    send_beat(vrp_pkg::MODE_READ, vrp_pkg::REG_STATUS, 8'h00);
    send_beat(vrp_pkg::MODE_WRITE, vrp_pkg::REG_SCROLL, 8'h00);
    send_beat(vrp_pkg::MODE_WRITE, vrp_pkg::REG_SCROLL, 8'hFF);
    send_beat(vrp_pkg::MODE_STATUS, vrp_pkg::REG_DATA, 8'h1F);
    send_beat(vrp_pkg::MODE_READ, vrp_pkg::REG_STATUS, 8'h00);
  endtask

  task automatic test_data_port();
    send_beat(vrp_pkg::MODE_WRITE, vrp_pkg::REG_CONTROL, 8'h00);
    point_vram(16'h3F10);
    send_beat(vrp_pkg::MODE_WRITE, vrp_pkg::REG_DATA, 8'h2A);
    point_vram(16'h3F00);
    send_beat(vrp_pkg::MODE_READ, vrp_pkg::REG_DATA, 8'h00);
    send_beat(vrp_pkg::MODE_WRITE, vrp_pkg::REG_CONTROL, 8'h04);
    point_vram(16'h3FE0);
    send_beat(vrp_pkg::MODE_READ, vrp_pkg::REG_DATA, 8'h00);
    send_beat(vrp_pkg::MODE_READ, vrp_pkg::REG_DATA, 8'h00);
    send_beat(vrp_pkg::MODE_WRITE, vrp_pkg::REG_DATA, 8'h55);
    send_beat(vrp_pkg::MODE_READ, vrp_pkg::REG_DATA, 8'h00);
  endtask

  task automatic test_mirroring();
    logic [15:0] off;
    logic [15:0] a;
    for (int k = 0; k < 4; k++) begin
      set_mirroring(MirrorOrder[k]);
      off = 16'($urandom_range(0, 16'h02FF));
      for (int q = 0; q < 4; q++) begin
        point_vram(16'h2000 + 16'(q) * 16'h0400 + off);
        send_beat(vrp_pkg::MODE_WRITE, vrp_pkg::REG_DATA, 8'($urandom));
      end
      for (int q = 0; q < 4; q++) begin
        a = ((q == 0) ? 16'h3000 : 16'h2000) + 16'(q) * 16'h0400 + off;
        point_vram(a);
        send_beat(vrp_pkg::MODE_READ, vrp_pkg::REG_DATA, 8'h00);
        send_beat(vrp_pkg::MODE_READ, vrp_pkg::REG_DATA, 8'h00);
      end
    end
  endtask

  task automatic test_random_traffic();
    int unsigned start;
    int unsigned phase_end;
    int unsigned len;
    logic [15:0] base;
    logic [7:0]  ctrl;
    bit          paused;
    start = beats_sent;
    paused = 1'b0;
    for (int phase = 0; phase < 4; phase++) begin
      set_mirroring(2'($urandom_range(0, 3)));
      phase_end = start + (phase + 1) * RandomBeats / 4;
      while (beats_sent < phase_end) begin
        if ($urandom_range(0, 9) < 7) begin
          case ($urandom_range(0, 9))
            0, 1, 2: base = 16'($urandom_range(0, 16'h1FFF));
            3, 4, 5: base = 16'($urandom_range(16'h2000, 16'h3EFF));
            6, 7:    base = 16'($urandom_range(16'h3F00, 16'h3FFF));
            default: base = CornerBases[$urandom_range(0, 5)];
          endcase
          len = $urandom_range(1, 10);
          if ($urandom_range(0, 2) == 0) begin
            ctrl = 8'($urandom);
            send_beat(vrp_pkg::MODE_WRITE, vrp_pkg::REG_CONTROL, ctrl);
          end
          point_vram(base);
          repeat (len) send_beat(vrp_pkg::MODE_WRITE, vrp_pkg::REG_DATA, 8'($urandom));
          if ($urandom_range(0, 3) == 0) begin
            send_beat(2'($urandom_range(0, 2)), vrp_pkg::REG_OAM_DATA, 8'($urandom));
          end
          point_vram(base);
          repeat (len + 1) send_beat(vrp_pkg::MODE_READ, vrp_pkg::REG_DATA, 8'($urandom));
        end else begin
          repeat ($urandom_range(1, 6)) begin
            send_beat(2'($urandom), 3'($urandom), 8'($urandom));
          end
        end
        if (phase == 2 && !paused && beats_sent >= phase_end - RandomBeats / 8) begin
          drain_results();
          paused = 1'b1;
        end
      end
    end
  endtask

  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_style = 2'($urandom_range(0, 3));
      stall_left = $urandom_range(10, 80);
    end
    stall_left--;
    case (stall_style)
      StallNone:   out_if.ready <= 1'b1;
      StallRandom: out_if.ready <= 1'($urandom_range(0, 1));
      StallSparse: out_if.ready <= (stall_left % 4 == 0);
      default:     out_if.ready <= (stall_left < 3);
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      if (read_data_q.size() == 0) begin
        error_count++;
        $display("%0t: unexpected result beat, actual read_data %02h", $time,
                 out_if.read_data);
      end else begin
        want = read_data_q.pop_front();
        if (out_if.read_data !== want) begin
          error_count++;
          $display("%0t: read_data mismatch, expected %02h, actual %02h", $time, want,
                   out_if.read_data);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QuietLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.mode = vrp_pkg::MODE_READ;
    in_if.reg_index = vrp_pkg::REG_CONTROL;
    in_if.write_data = 8'h00;
    cfg_if.valid = 1'b0;
    cfg_if.mirror_mode = vrp_pkg::MIRROR_VERTICAL;
    out_if.ready = 1'b0;
    mirror_q = vrp_pkg::MIRROR_VERTICAL;
    ctrl_q = 8'h00;
    mask_q = 8'h00;
    status_q = 8'h00;
    oam_addr_q = 8'h00;
    oam_data_q = 8'h00;
    toggle_q = 1'b0;
    fine_x_q = 3'd0;
    t_addr = 16'h0000;
    v_addr = 16'h0000;
    rd_buf = 8'h00;
    error_count = 0;
    beats_sent = 0;
    burst_left = 0;
    quiet_cycles = 0;
    stall_left = 0;
    stall_style = StallNone;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_register_file();
    test_status_flags();
    test_data_port();
    test_mirroring();
    test_random_traffic();
    drain_results();

    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/vrp_pkg.sv
rtl/vrp_if.sv
rtl/vrp_vram.sv
rtl/video_register_port_with_vram_mapping.sv
test/video_register_port_with_vram_mapping_tb.sv
